@@ src/gclt_pkg.sv @@
// Shared constants, types and scaling functions of the G-code line tokenizer.
package gclt_pkg;

  localparam int unsigned FracDigits  = 4;
  localparam int unsigned ValueWidth  = 48;
  localparam int unsigned MagWidth    = ValueWidth - 1;
  localparam int unsigned NumLetters  = 26;
  localparam int unsigned LetterWidth = 5;
  localparam int unsigned CmdWidth    = 24;
  localparam int unsigned ScaleWidth  = 24;

  localparam logic [LetterWidth-1:0] NotUpper = LetterWidth'(NumLetters);
  localparam logic [CmdWidth:0]      CmdLimit = (CmdWidth + 1)'(1) << CmdWidth;
  localparam logic [MagWidth-1:0]    MaxMag   = '1;
  localparam logic [2:0]             FracLimit = 3'(FracDigits);

  // line status codes
  localparam logic [2:0] StatusOk        = 3'd0;
  localparam logic [2:0] StatusEmpty     = 3'd1;
  localparam logic [2:0] StatusBadCmd    = 3'd2;
  localparam logic [2:0] StatusBadParam  = 3'd3;
  localparam logic [2:0] StatusBadLetter = 3'd4;

  // character codes
  localparam logic [7:0] ChNul     = 8'h00;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChMinus   = 8'h2D;
  localparam logic [7:0] ChPoint   = 8'h2E;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChSemi    = 8'h3B;
  localparam logic [7:0] ChUpperA  = 8'h41;
  localparam logic [7:0] ChUpperZ  = 8'h5A;
  localparam logic [7:0] ChLowerA  = 8'h61;
  localparam logic [7:0] ChLowerZ  = 8'h7A;

  typedef struct packed {
    logic                   en;
    logic [LetterWidth-1:0] addr;
    logic [ValueWidth-1:0]  data;
  } ram_wr_t;

  typedef struct packed {
    logic                   en;
    logic [LetterWidth-1:0] addr;
  } ram_rd_t;

  typedef struct packed {
    logic                   valid;
    logic [2:0]             status;
    logic [LetterWidth-1:0] cmd_letter;
    logic [CmdWidth-1:0]    cmd_number;
    logic [NumLetters-1:0]  present;
  } line_close_t;

  function automatic logic [ScaleWidth-1:0] pow10(int unsigned n);
    logic [ScaleWidth-1:0] r;
    r = ScaleWidth'(1);
    for (int unsigned i = 0; i < n; i++) begin
      r = ScaleWidth'(r * 10);
    end
    return r;
  endfunction

  // weight of an integer digit: d * 10^FracDigits
  function automatic logic [ScaleWidth-1:0] int_scale(logic [3:0] d);
    return ScaleWidth'(ScaleWidth'(d) * pow10(FracDigits));
  endfunction

  // weight of fraction digit number cnt: d * 10^(FracDigits-1-cnt)
  function automatic logic [ScaleWidth-1:0] frac_scale(logic [2:0] cnt, logic [3:0] d);
    logic [ScaleWidth-1:0] r;
    r = ScaleWidth'(1);
    for (int i = 0; i < 8; i++) begin
      if (i + int'(cnt) + 1 < int'(FracDigits)) begin
        r = ScaleWidth'(r * 10);
      end
    end
    return ScaleWidth'(ScaleWidth'(d) * r);
  endfunction

endpackage

@@ src/gclt_lexer.sv @@
// Per-byte line scanner: command, parameters and value accumulation.
module gclt_lexer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [7:0]           text_byte_i,
  output gclt_pkg::ram_wr_t    wr_o,
  output gclt_pkg::line_close_t close_o
);

  typedef enum logic [6:0] {
    PhStart  = 7'b0000001,
    PhCmdLet = 7'b0000010,
    PhCmdNum = 7'b0000100,
    PhParam  = 7'b0001000,
    PhPLet   = 7'b0010000,
    PhPVal   = 7'b0100000,
    PhSkip   = 7'b1000000
  } phase_e;

  phase_e phase_q, phase_d;
  logic [gclt_pkg::LetterWidth-1:0] cmd_letter_q, cmd_letter_d;
  logic [gclt_pkg::CmdWidth:0]      cmd_number_q, cmd_number_d;
  logic [2:0]                       status_q, status_d;
  logic [gclt_pkg::LetterWidth-1:0] cur_letter_q, cur_letter_d;
  logic                             cur_neg_q, cur_neg_d;
  logic                             cur_point_q, cur_point_d;
  logic [2:0]                       cur_frac_q, cur_frac_d;
  logic [gclt_pkg::MagWidth-1:0]    cur_mag_q, cur_mag_d;
  logic [gclt_pkg::NumLetters-1:0]  present_q, present_d;

  logic [7:0] c;
  logic       is_eol, is_space, is_semi, is_term, is_digit, is_upper, is_lower;
  logic [7:0] upper_off;
  logic [4:0] upper_idx;
  logic [3:0] digit_val;

  logic [gclt_pkg::MagWidth+3:0] int_sum;
  logic [gclt_pkg::MagWidth:0]   frac_sum;
  logic [gclt_pkg::MagWidth-1:0] mag_digit;
  logic [2:0]                    frac_digit;
  logic [gclt_pkg::CmdWidth+4:0] cmd_prod;
  logic [gclt_pkg::ValueWidth-1:0] commit_val;

  assign c         = text_byte_i;
  assign is_eol    = (c == gclt_pkg::ChNewline) || (c == gclt_pkg::ChNul);
  assign is_space  = (c == gclt_pkg::ChSpace);
  assign is_semi   = (c == gclt_pkg::ChSemi);
  assign is_term   = is_eol || is_space || is_semi;
  assign is_digit  = (c >= gclt_pkg::ChZero) && (c <= gclt_pkg::ChNine);
  assign is_upper  = (c >= gclt_pkg::ChUpperA) && (c <= gclt_pkg::ChUpperZ);
  assign is_lower  = (c >= gclt_pkg::ChLowerA) && (c <= gclt_pkg::ChLowerZ);
  assign upper_off = c - gclt_pkg::ChUpperA;
  assign upper_idx = upper_off[4:0];
  assign digit_val = c[3:0];

  // integer digit: mag*10 + d*10^frac, saturating
  assign int_sum = (gclt_pkg::MagWidth + 4)'({cur_mag_q, 3'b000})
                 + (gclt_pkg::MagWidth + 4)'({cur_mag_q, 1'b0})
                 + (gclt_pkg::MagWidth + 4)'(gclt_pkg::int_scale(digit_val));
  // fraction digit: mag + d*10^(frac-1-count), saturating
  assign frac_sum = (gclt_pkg::MagWidth + 1)'(cur_mag_q)
                  + (gclt_pkg::MagWidth + 1)'(gclt_pkg::frac_scale(cur_frac_q, digit_val));

  always_comb begin
    mag_digit  = cur_mag_q;
    frac_digit = cur_frac_q;
    if (!cur_point_q) begin
      mag_digit = (int_sum > (gclt_pkg::MagWidth + 4)'(gclt_pkg::MaxMag)) ?
                  gclt_pkg::MaxMag : int_sum[gclt_pkg::MagWidth-1:0];
    end else if (cur_frac_q < gclt_pkg::FracLimit) begin
      mag_digit  = (frac_sum > (gclt_pkg::MagWidth + 1)'(gclt_pkg::MaxMag)) ?
                   gclt_pkg::MaxMag : frac_sum[gclt_pkg::MagWidth-1:0];
      frac_digit = cur_frac_q + 3'd1;
    end
  end

  assign cmd_prod = (gclt_pkg::CmdWidth + 5)'({cmd_number_q, 3'b000})
                  + (gclt_pkg::CmdWidth + 5)'({cmd_number_q, 1'b0})
                  + (gclt_pkg::CmdWidth + 5)'(digit_val);

  assign commit_val = cur_neg_q ?
      (gclt_pkg::ValueWidth'(0) - gclt_pkg::ValueWidth'(cur_mag_q)) :
      gclt_pkg::ValueWidth'(cur_mag_q);

  always_comb begin
    phase_d      = phase_q;
    cmd_letter_d = cmd_letter_q;
    cmd_number_d = cmd_number_q;
    status_d     = status_q;
    cur_letter_d = cur_letter_q;
    cur_neg_d    = cur_neg_q;
    cur_point_d  = cur_point_q;
    cur_frac_d   = cur_frac_q;
    cur_mag_d    = cur_mag_q;
    present_d    = present_q;
    wr_o         = '0;

    if (accept_i) begin
      unique case (phase_q)
        PhStart: begin
          if (is_eol || is_semi) begin
            status_d = gclt_pkg::StatusEmpty;
            phase_d  = PhSkip;
          end else if (is_upper) begin
            cmd_letter_d = upper_idx;
            phase_d      = PhCmdLet;
          end else if (!is_space) begin
            status_d = gclt_pkg::StatusBadCmd;
            phase_d  = PhSkip;
          end
        end
        PhCmdLet: begin
          if (is_digit) begin
            cmd_number_d = (gclt_pkg::CmdWidth + 1)'(digit_val);
            phase_d      = PhCmdNum;
          end else begin
            status_d = gclt_pkg::StatusBadCmd;
            phase_d  = PhSkip;
          end
        end
        PhCmdNum: begin
          if (is_digit) begin
            if (cmd_number_q < gclt_pkg::CmdLimit) begin
              cmd_number_d = (cmd_prod > (gclt_pkg::CmdWidth + 5)'(gclt_pkg::CmdLimit)) ?
                             gclt_pkg::CmdLimit : cmd_prod[gclt_pkg::CmdWidth:0];
            end
          end else if (is_term) begin
            if (cmd_number_q >= gclt_pkg::CmdLimit) begin
              status_d = gclt_pkg::StatusBadCmd;
              phase_d  = PhSkip;
            end else begin
              phase_d = is_space ? PhParam : PhSkip;
            end
          end else begin
            status_d = gclt_pkg::StatusBadCmd;
            phase_d  = PhSkip;
          end
        end
        PhParam: begin
          if (is_semi) begin
            phase_d = PhSkip;
          end else if (is_upper || is_lower) begin
            cur_letter_d = is_upper ? upper_idx : gclt_pkg::NotUpper;
            cur_neg_d    = 1'b0;
            cur_point_d  = 1'b0;
            cur_frac_d   = '0;
            cur_mag_d    = '0;
            phase_d      = PhPLet;
          end else if (!(is_eol || is_space)) begin
            status_d = gclt_pkg::StatusBadParam;
            phase_d  = PhSkip;
          end
        end
        PhPLet, PhPVal: begin
          if (is_term) begin
            if (cur_letter_q >= gclt_pkg::NotUpper) begin
              status_d = gclt_pkg::StatusBadLetter;
              phase_d  = PhSkip;
            end else begin
              wr_o.en                 = 1'b1;
              wr_o.addr               = cur_letter_q;
              wr_o.data               = commit_val;
              present_d[cur_letter_q] = 1'b1;
              phase_d                 = is_space ? PhParam : PhSkip;
            end
            cur_letter_d = '0;
            cur_neg_d    = 1'b0;
            cur_point_d  = 1'b0;
            cur_frac_d   = '0;
            cur_mag_d    = '0;
          end else if (is_digit) begin
            cur_mag_d  = mag_digit;
            cur_frac_d = frac_digit;
            phase_d    = PhPVal;
          end else if ((c == gclt_pkg::ChPoint) && !cur_point_q) begin
            cur_point_d = 1'b1;
            phase_d     = PhPVal;
          end else if ((c == gclt_pkg::ChMinus) && (phase_q == PhPLet)) begin
            cur_neg_d = 1'b1;
            phase_d   = PhPVal;
          end else begin
            status_d     = gclt_pkg::StatusBadParam;
            phase_d      = PhSkip;
            cur_letter_d = '0;
            cur_neg_d    = 1'b0;
            cur_point_d  = 1'b0;
            cur_frac_d   = '0;
            cur_mag_d    = '0;
          end
        end
        PhSkip: begin
          phase_d = PhSkip;
        end
        default: begin
          phase_d = PhSkip;
        end
      endcase
    end

    close_o.valid      = accept_i && is_eol;
    close_o.status     = status_d;
    close_o.cmd_letter = cmd_letter_d;
    close_o.cmd_number = cmd_number_d[gclt_pkg::CmdWidth-1:0];
    close_o.present    = present_d;

    // line end: everything back to the line-start state
    if (close_o.valid) begin
      phase_d      = PhStart;
      cmd_letter_d = '0;
      cmd_number_d = '0;
      status_d     = gclt_pkg::StatusOk;
      cur_letter_d = '0;
      cur_neg_d    = 1'b0;
      cur_point_d  = 1'b0;
      cur_frac_d   = '0;
      cur_mag_d    = '0;
      present_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhStart;
      cmd_letter_q <= '0;
      cmd_number_q <= '0;
      status_q     <= gclt_pkg::StatusOk;
      cur_letter_q <= '0;
      cur_neg_q    <= 1'b0;
      cur_point_q  <= 1'b0;
      cur_frac_q   <= '0;
      cur_mag_q    <= '0;
      present_q    <= '0;
    end else begin
      phase_q      <= phase_d;
      cmd_letter_q <= cmd_letter_d;
      cmd_number_q <= cmd_number_d;
      status_q     <= status_d;
      cur_letter_q <= cur_letter_d;
      cur_neg_q    <= cur_neg_d;
      cur_point_q  <= cur_point_d;
      cur_frac_q   <= cur_frac_d;
      cur_mag_q    <= cur_mag_d;
      present_q    <= present_d;
    end
  end

  a_wr_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.en |-> accept_i && (wr_o.addr < gclt_pkg::NotUpper))
    else $error("parameter write without an upper-case letter");

  a_close_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    close_o.valid |=> (phase_q == PhStart) && (present_q == '0))
    else $error("line state not cleared after line end");

endmodule

@@ src/gclt_param_ram.sv @@
// Parameter value memory: one write port, one registered read port.
module gclt_param_ram (
  input  logic                            clk_i,
  input  gclt_pkg::ram_wr_t               wr_i,
  input  gclt_pkg::ram_rd_t               rd_i,
  output logic [gclt_pkg::ValueWidth-1:0] rdata_o
);

  logic [gclt_pkg::ValueWidth-1:0] mem_q [gclt_pkg::NumLetters];
  logic [gclt_pkg::ValueWidth-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rdata_q <= mem_q[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/gclt_emitter.sv @@
// Line-end sequencer: walks set letters through the RAM, then the status word.
module gclt_emitter (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  gclt_pkg::line_close_t            close_i,
  output gclt_pkg::ram_rd_t                rd_o,
  input  logic [gclt_pkg::ValueWidth-1:0]  rdata_i,
  output logic                             busy_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             out_summary_o,
  output logic [gclt_pkg::LetterWidth-1:0] out_letter_o,
  output logic [gclt_pkg::ValueWidth-1:0]  out_value_o,
  output logic [2:0]                       out_status_o,
  output logic [gclt_pkg::LetterWidth-1:0] out_cmd_letter_o,
  output logic [gclt_pkg::CmdWidth-1:0]    out_cmd_number_o
);

  typedef enum logic [3:0] {
    EmIdle  = 4'b0001,
    EmScan  = 4'b0010,
    EmFetch = 4'b0100,
    EmHold  = 4'b1000
  } em_state_e;

  em_state_e state_q, state_d;
  logic [gclt_pkg::NumLetters-1:0]  mask_q, mask_d;
  logic [2:0]                       status_q;
  logic [gclt_pkg::LetterWidth-1:0] cmd_letter_q;
  logic [gclt_pkg::CmdWidth-1:0]    cmd_number_q;
  logic [gclt_pkg::LetterWidth-1:0] rd_letter_q;
  logic                             out_valid_q, out_valid_d;
  logic                             out_summary_q;
  logic [gclt_pkg::LetterWidth-1:0] out_letter_q;
  logic [gclt_pkg::ValueWidth-1:0]  out_value_q;
  logic [2:0]                       out_status_q;
  logic [gclt_pkg::LetterWidth-1:0] out_cmd_letter_q;
  logic [gclt_pkg::CmdWidth-1:0]    out_cmd_number_q;

  logic [gclt_pkg::LetterWidth-1:0] first_idx;
  logic                             any_set;
  logic                             load_param, load_sum;

  // lowest set letter
  always_comb begin
    first_idx = '0;
    for (int i = gclt_pkg::NumLetters - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        first_idx = gclt_pkg::LetterWidth'(i);
      end
    end
  end
  assign any_set = |mask_q;

  always_comb begin
    state_d     = state_q;
    mask_d      = mask_q;
    out_valid_d = out_valid_q;
    rd_o        = '0;
    load_param  = 1'b0;
    load_sum    = 1'b0;
    unique case (state_q)
      EmIdle: begin
        if (close_i.valid) begin
          mask_d  = close_i.present;
          state_d = EmScan;
        end
      end
      EmScan: begin
        if (any_set) begin
          rd_o.en           = 1'b1;
          rd_o.addr         = first_idx;
          mask_d[first_idx] = 1'b0;
          state_d           = EmFetch;
        end else begin
          load_sum    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = EmHold;
        end
      end
      EmFetch: begin
        load_param  = 1'b1;
        out_valid_d = 1'b1;
        state_d     = EmHold;
      end
      EmHold: begin
        if (out_valid_q && !out_stall_i) begin
          out_valid_d = 1'b0;
          state_d     = out_summary_q ? EmIdle : EmScan;
        end
      end
      default: begin
        state_d = EmIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= EmIdle;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (close_i.valid && (state_q == EmIdle)) begin
      status_q <= close_i.status;
      if (close_i.status == gclt_pkg::StatusOk) begin
        cmd_letter_q <= close_i.cmd_letter;
        cmd_number_q <= close_i.cmd_number;
      end else begin
        cmd_letter_q <= '0;
        cmd_number_q <= '0;
      end
    end
    if (rd_o.en) begin
      rd_letter_q <= rd_o.addr;
    end
    if (load_param) begin
      out_summary_q    <= 1'b0;
      out_letter_q     <= rd_letter_q;
      out_value_q      <= rdata_i;
      out_status_q     <= gclt_pkg::StatusOk;
      out_cmd_letter_q <= '0;
      out_cmd_number_q <= '0;
    end else if (load_sum) begin
      out_summary_q    <= 1'b1;
      out_letter_q     <= '0;
      out_value_q      <= '0;
      out_status_q     <= status_q;
      out_cmd_letter_q <= cmd_letter_q;
      out_cmd_number_q <= cmd_number_q;
    end
  end

  assign busy_o           = (state_q != EmIdle);
  assign out_valid_o      = out_valid_q;
  assign out_summary_o    = out_summary_q;
  assign out_letter_o     = out_letter_q;
  assign out_value_o      = out_value_q;
  assign out_status_o     = out_status_q;
  assign out_cmd_letter_o = out_cmd_letter_q;
  assign out_cmd_number_o = out_cmd_number_q;

  a_close_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    close_i.valid |-> (state_q == EmIdle))
    else $error("line end arrived while results were draining");

  a_fetch_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == EmFetch) |=> out_valid_q && !out_summary_q)
    else $error("RAM fetch did not fill the output register");

  a_scan_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == EmScan) |-> !out_valid_q)
    else $error("scan step with a word still pending");

endmodule

@@ src/gcode_line_tokenizer.sv @@
// Top level of the G-code line tokenizer.
//
// Input channel: one text byte per word (in_valid_i / in_stall_o). Spaces
// are skipped; newline or NUL closes the line.
// Output channel: per closed line, one word per upper-case parameter letter
// that was set (A..Z order, is_summary_o = 0), then one status word
// (is_summary_o = 1, last_o = 1) with the line status and command.
// Throughput: mid-line bytes are taken one per cycle. At a line end the
// input is stalled from the next cycle until the status word is taken.
// Each parameter word passes through scan, RAM read and output hold, and
// the status word through scan and output hold; the single read port of
// the parameter RAM and the one output register mean that the next word
// is not started before the last one is taken.
// After the line-end byte is taken, out_valid_o rises once the sequencer
// has gone through scan and, when letters are set, the RAM read.
// A stalled output holds its word; the sequencer simply waits.
// Reset puts the scanner at line start with no parameters set; the RAM is
// not cleared, as only letters marked present are ever read.
module gcode_line_tokenizer (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [7:0]                             text_byte_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic                                   is_summary_o,
  output logic [gclt_pkg::LetterWidth-1:0]       param_letter_o,
  output logic signed [gclt_pkg::ValueWidth-1:0] param_value_o,
  output logic [2:0]                             line_status_o,
  output logic [gclt_pkg::LetterWidth-1:0]       command_letter_o,
  output logic [gclt_pkg::CmdWidth-1:0]          command_number_o,
  output logic                                   last_o
);

  gclt_pkg::ram_wr_t     ram_wr;
  gclt_pkg::ram_rd_t     ram_rd;
  gclt_pkg::line_close_t line_close;
  logic [gclt_pkg::ValueWidth-1:0] ram_rdata;
  logic [gclt_pkg::ValueWidth-1:0] out_value;
  logic busy;
  logic accept;

  // bytes are held off only while a line's results drain
  assign in_stall_o = busy;
  assign accept     = in_valid_i && !busy;

  gclt_lexer u_lexer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .text_byte_i (text_byte_i),
    .wr_o        (ram_wr),
    .close_o     (line_close)
  );

  // one entry per parameter letter, last write wins
  gclt_param_ram u_ram (
    .clk_i   (clk_i),
    .wr_i    (ram_wr),
    .rd_i    (ram_rd),
    .rdata_o (ram_rdata)
  );

  gclt_emitter u_emitter (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .close_i          (line_close),
    .rd_o             (ram_rd),
    .rdata_i          (ram_rdata),
    .busy_o           (busy),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_summary_o    (is_summary_o),
    .out_letter_o     (param_letter_o),
    .out_value_o      (out_value),
    .out_status_o     (line_status_o),
    .out_cmd_letter_o (command_letter_o),
    .out_cmd_number_o (command_number_o)
  );

  assign param_value_o = $signed(out_value);
  assign last_o        = is_summary_o;

endmodule

@@ test/gcode_line_tokenizer_checker.sv @@
// Scoreboard for the G-code line tokenizer: predicts the result words and compares them.
module gcode_line_tokenizer_checker
  import gclt_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [7:0]                    text_byte_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic                          is_summary_i,
  input  logic [LetterWidth-1:0]        param_letter_i,
  input  logic signed [ValueWidth-1:0]  param_value_i,
  input  logic [2:0]                    line_status_i,
  input  logic [LetterWidth-1:0]        command_letter_i,
  input  logic [CmdWidth-1:0]           command_number_i,
  input  logic                          last_i,
  output int                            fail_count_o,
  output int                            pending_o
);

  typedef enum logic [3:0] {
    ScanStart, ScanCmdLetter, ScanCmdNumber, ScanParam, ScanParamLetter, ScanParamValue,
    ScanSkip
  } scan_phase_e;

  typedef struct packed {
    logic                   is_summary;
    logic [LetterWidth-1:0] letter;
    logic [ValueWidth-1:0]  value;
    logic [2:0]             status;
    logic [LetterWidth-1:0] cmd_letter;
    logic [CmdWidth-1:0]    cmd_number;
    logic                   last;
  } token_t;

  token_t expected_tokens[$];

  scan_phase_e            phase;
  logic [LetterWidth-1:0] cmd_letter;
  logic [CmdWidth:0]      cmd_number;
  logic [2:0]             status;
  logic [LetterWidth-1:0] cur_letter;
  bit                     cur_negative;
  bit                     cur_point;
  logic [2:0]             cur_frac;
  logic [MagWidth-1:0]    cur_mag;
  bit                     present[NumLetters];
  logic [ValueWidth-1:0]  store[NumLetters];

  function automatic void clear_value();
    cur_letter   = '0;
    cur_negative = 1'b0;
    cur_point    = 1'b0;
    cur_frac     = '0;
    cur_mag      = '0;
  endfunction

  function automatic void clear_line();
    phase      = ScanStart;
    cmd_letter = '0;
    cmd_number = '0;
    status     = StatusOk;
    clear_value();
    for (int i = 0; i < NumLetters; i++) begin
      present[i] = 1'b0;
      store[i]   = '0;
    end
  endfunction

  // integer digits scale by 10^FracDigits; fraction digits beyond FracDigits drop
  function automatic void add_digit(int unsigned d);
    longint unsigned top_mag, weight, mag;
    top_mag = longint'(MaxMag);
    mag     = longint'(cur_mag);
    weight  = d;
    if (!cur_point) begin
      repeat (FracDigits) weight *= 10;
      if (mag > (top_mag - weight) / 10) mag = top_mag;
      else mag = mag * 10 + weight;
    end else if (cur_frac < FracLimit) begin
      repeat (FracDigits - 1 - cur_frac) weight *= 10;
      mag = (mag > top_mag - weight) ? top_mag : mag + weight;
      cur_frac++;
    end
    cur_mag = MagWidth'(mag);
  endfunction

  function automatic bit commit_param();
    if (cur_letter >= NotUpper) begin
      status = StatusBadLetter;
      phase  = ScanSkip;
      clear_value();
      return 1'b0;
    end
    present[cur_letter] = 1'b1;
    store[cur_letter]   = cur_negative ? ValueWidth'(0) - {1'b0, cur_mag} : {1'b0, cur_mag};
    clear_value();
    return 1'b1;
  endfunction

  function automatic void close_line();
    token_t tok;
    for (int i = 0; i < NumLetters; i++) begin
      if (present[i]) begin
        tok        = '0;
        tok.letter = LetterWidth'(i);
        tok.value  = store[i];
        expected_tokens.push_back(tok);
      end
    end
    tok            = '0;
    tok.is_summary = 1'b1;
    tok.status     = status;
    if (status == StatusOk) begin
      tok.cmd_letter = cmd_letter;
      tok.cmd_number = cmd_number[CmdWidth-1:0];
    end
    tok.last = 1'b1;
    expected_tokens.push_back(tok);
    clear_line();
  endfunction

  function automatic void tokenize_byte(logic [7:0] c);
    bit eol, term, digit, upper, lower;
    logic [31:0] next_num;
    eol   = (c == ChNewline) || (c == ChNul);
    term  = eol || (c == ChSpace) || (c == ChSemi);
    digit = (c >= ChZero) && (c <= ChNine);
    upper = (c >= ChUpperA) && (c <= ChUpperZ);
    lower = (c >= ChLowerA) && (c <= ChLowerZ);
    case (phase)
      ScanStart: begin
        if (eol || c == ChSemi) begin
          status = StatusEmpty;
          phase  = ScanSkip;
        end else if (c == ChSpace) begin
        end else if (upper) begin
          cmd_letter = LetterWidth'(c - ChUpperA);
          phase      = ScanCmdLetter;
        end else begin
          status = StatusBadCmd;
          phase  = ScanSkip;
        end
      end
      ScanCmdLetter: begin
        if (digit) begin
          cmd_number = (CmdWidth + 1)'(c - ChZero);
          phase      = ScanCmdNumber;
        end else begin
          status = StatusBadCmd;
          phase  = ScanSkip;
        end
      end
      ScanCmdNumber: begin
        if (digit) begin
          if (cmd_number < CmdLimit) begin
            next_num = 32'(cmd_number) * 10 + 32'(c - ChZero);
            if (next_num > 32'(CmdLimit)) next_num = 32'(CmdLimit);
            cmd_number = (CmdWidth + 1)'(next_num);
          end
        end else if (term) begin
          if (cmd_number >= CmdLimit) begin
            status = StatusBadCmd;
            phase  = ScanSkip;
          end else begin
            phase = (c == ChSpace) ? ScanParam : ScanSkip;
          end
        end else begin
          status = StatusBadCmd;
          phase  = ScanSkip;
        end
      end
      ScanParam: begin
        if (c == ChSemi) begin
          phase = ScanSkip;
        end else if (eol || c == ChSpace) begin
        end else if (upper || lower) begin
          clear_value();
          cur_letter = upper ? LetterWidth'(c - ChUpperA) : NotUpper;
          phase      = ScanParamLetter;
        end else begin
          status = StatusBadParam;
          phase  = ScanSkip;
        end
      end
      ScanParamLetter, ScanParamValue: begin
        if (term) begin
          if (commit_param()) phase = (c == ChSpace) ? ScanParam : ScanSkip;
        end else if (digit) begin
          add_digit(int'(c - ChZero));
          phase = ScanParamValue;
        end else if (c == ChPoint && !cur_point) begin
          cur_point = 1'b1;
          phase     = ScanParamValue;
        end else if (c == ChMinus && phase == ScanParamLetter) begin
          cur_negative = 1'b1;
          phase        = ScanParamValue;
        end else begin
          status = StatusBadParam;
          phase  = ScanSkip;
          clear_value();
        end
      end
      default: phase = ScanSkip;
    endcase
    if (eol) close_line();
  endfunction

  task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    token_t want, got;
    if (!rst_ni) begin
      clear_line();
      expected_tokens.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (in_valid_i && !in_stall_i) tokenize_byte(text_byte_i);
      if (out_valid_i && !out_stall_i) begin
        got = {is_summary_i, param_letter_i, param_value_i, line_status_i,
               command_letter_i, command_number_i, last_i};
        if (expected_tokens.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %0h", $time, got);
          fail_count_o++;
        end else begin
          want = expected_tokens.pop_front();
          check_field("is_summary", want.is_summary, got.is_summary);
          check_field("param_letter", want.letter, got.letter);
          check_field("param_value", want.value, got.value);
          check_field("line_status", want.status, got.status);
          check_field("command_letter", want.cmd_letter, got.cmd_letter);
          check_field("command_number", want.cmd_number, got.cmd_number);
          check_field("last", want.last, got.last);
        end
      end
      pending_o = expected_tokens.size();
    end
  end

endmodule

@@ test/gcode_line_tokenizer_tb.sv @@
// Testbench top for the G-code line tokenizer: clock, reset, text stimulus and verdict.
module gcode_line_tokenizer_tb;
  import gclt_pkg::*;

  // worst case is far below this: ~450 bytes, each after a random gap, a few dozen
  // lines of up to 27 words each, every word held by a random stall
  localparam int CycleLimit = 400000;
  localparam int RandomBytes = 250;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [7:0]                    text_byte;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic                          is_summary;
  logic [LetterWidth-1:0]        param_letter;
  logic signed [ValueWidth-1:0]  param_value;
  logic [2:0]                    line_status;
  logic [LetterWidth-1:0]        command_letter;
  logic [CmdWidth-1:0]           command_number;
  logic                          last;

  int fail_count;
  int pending;
  int cycle_count = 0;

  // receiver side state
  logic out_word_taken = 1'b0;
  bit   quiet_rx = 1'b0;
  int   rx_hold = 0;

  // sender side state
  bit         quiet_tx;
  logic [7:0] line_q[$];
  int         random_sent;

  gcode_line_tokenizer uut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .text_byte_i      (text_byte),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .is_summary_o     (is_summary),
    .param_letter_o   (param_letter),
    .param_value_o    (param_value),
    .line_status_o    (line_status),
    .command_letter_o (command_letter),
    .command_number_o (command_number),
    .last_o           (last)
  );

  gcode_line_tokenizer_checker checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .text_byte_i      (text_byte),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .is_summary_i     (is_summary),
    .param_letter_i   (param_letter),
    .param_value_i    (param_value),
    .line_status_i    (line_status),
    .command_letter_i (command_letter),
    .command_number_i (command_number),
    .last_i           (last),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: after each taken word draw a random stall length. The hold
  // counts down whether or not a word is waiting, so stalls land on every
  // point of the drain sequence. Now and then switch into or out of a
  // stretch with no stalls at all.
  always @(posedge clk) out_word_taken <= out_valid && !out_stall;

  always @(negedge clk) begin
    if (out_word_taken) begin
      if ($urandom_range(0, 15) == 0) quiet_rx = !quiet_rx;
      rx_hold = quiet_rx ? 0 : $urandom_range(0, 17);
    end else if (rx_hold != 0) begin
      rx_hold--;
    end
    out_stall <= (rx_hold != 0);
  end

  // One text word. Called and returns at a falling edge; valid stays high
  // between back-to-back words, so it gets one assignment per step.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = quiet_tx ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    text_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_line();
    quiet_tx = ($urandom_range(0, 3) == 0);
    foreach (line_q[i]) send_byte(line_q[i]);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  task automatic send_text(input string s, input logic [7:0] ending);
    line_q.delete();
    add_text(s);
    line_q.push_back(ending);
    send_line();
  endtask

  task automatic add_digits(input int n);
    repeat (n) line_q.push_back(ChZero + 8'($urandom_range(0, 9)));
  endtask

  // Mostly well-formed lines with random content; one in ten is pure noise
  // over the whole byte range, one in ten a good line with one byte smashed.
  task automatic build_random_line();
    int kind;
    int pos;
    line_q.delete();
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(0, 8)) line_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 2)) line_q.push_back(ChSpace);
      if ($urandom_range(0, 3) == 0) line_q.push_back(ChUpperA + 8'($urandom_range(0, 25)));
      else add_text($urandom_range(0, 1) ? "G" : "M");
      case ($urandom_range(0, 9))
        // straddle the command number limit
        0: begin
          add_text("1677721");
          line_q.push_back(ChZero + 8'($urandom_range(5, 6)));
        end
        1: add_digits($urandom_range(8, 10));
        default: add_digits($urandom_range(1, 3));
      endcase
      repeat ($urandom_range(0, 5)) begin
        repeat ($urandom_range(1, 2)) line_q.push_back(ChSpace);
        if ($urandom_range(0, 11) == 0) line_q.push_back(ChLowerA + 8'($urandom_range(0, 25)));
        else line_q.push_back(ChUpperA + 8'($urandom_range(0, 25)));
        // one in eight is valueless
        if ($urandom_range(0, 7) != 0) begin
          if ($urandom_range(0, 2) == 0) line_q.push_back(ChMinus);
          if ($urandom_range(0, 7) == 0) add_digits($urandom_range(15, 20));  // saturates
          else add_digits($urandom_range(0, 3));
          if ($urandom_range(0, 1) != 0) begin
            line_q.push_back(ChPoint);
            add_digits($urandom_range(0, 6));
          end
        end
      end
      if ($urandom_range(0, 4) == 0) begin
        line_q.push_back(ChSemi);
        repeat ($urandom_range(0, 4)) line_q.push_back(8'($urandom_range(32, 126)));
      end
      if (kind == 1) begin
        pos = $urandom_range(0, line_q.size() - 1);
        line_q[pos] = 8'($urandom_range(0, 255));
      end
    end
    line_q.push_back(($urandom_range(0, 5) == 0) ? ChNul : ChNewline);
  endtask

  initial begin
    in_valid  = 1'b0;
    text_byte = 8'h00;
    rst_n     = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed lines: empty, comment ended by NUL, bad command forms, a command with a comment
    send_text("", ChNewline);
    send_text(";", ChNul);
    send_text("  g1", ChNewline);
    send_text("G", ChNewline);
    send_text("G1X", ChNewline);
    send_text("M16777216", ChNewline);
    send_text("G28;home", ChNewline);
    // largest command, letters A and Z, minus zero, dropped fraction digits,
    // valueless letter right at line end
    send_text("Z16777215 A-0 Z.00019 Q", ChNul);
    // saturation both ways, repeated letter, bare minus, valueless before comment
    send_text("A0 X12345678901234567890 Y-99999999999999999.9 X7 C- D-.5 B;c",
              ChNewline);
    // parameter format errors, upper-case letters before the error still come out
    send_text("G1 5", ChNewline);
    send_text("G1 X*", ChNewline);
    send_text("G1 A1 X1..2", ChNewline);
    send_text("G1 X1-", ChNewline);
    line_q.delete();
    add_text("G1 X1");
    line_q.push_back(8'hFF);
    line_q.push_back(ChNewline);
    send_line();
    // lower-case letter with a good value
    send_text("G1 Y2 x1 Z3", ChNewline);

    random_sent = 0;
    while (random_sent < RandomBytes) begin
      build_random_line();
      random_sent += line_q.size();
      send_line();
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
